// ===== design/adaptive_congestion_rate_control_macros.svh =====
// Assertion macros for the adaptive congestion rate control block.
`ifndef ADAPTIVE_CONGESTION_RATE_CONTROL_MACROS_SVH
`define ADAPTIVE_CONGESTION_RATE_CONTROL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acrc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acrc check failed");

`endif

// ===== design/acrc_pkg.sv =====
// Shared types and constants of the adaptive congestion rate control block.
package acrc_pkg;

    localparam logic [25:0] OFF_LOW  = 26'd1638400;
    localparam logic [25:0] OFF_HIGH = 26'd65536000;
    localparam logic [35:0] Q_SAT    = 36'd67108864000;

    localparam logic [15:0] CBR_TARGET_RST = 16'd44564;
    localparam logic [15:0] ALPHA_RST      = 16'd1049;
    localparam logic [15:0] BETA_RST       = 16'd79;
    localparam logic [20:0] STEP_MAX_RST   = 21'd8389;
    localparam logic [20:0] STEP_MIN_RST   = 21'h1FEF9E;
    localparam logic [24:0] FLOOR_RST      = 25'd10066;
    localparam logic [24:0] CEIL_RST       = 25'd503316;
    localparam logic [25:0] ON_TIME_RST    = 26'd32768;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_TX     = 2'd2,
        REQ_QUERY  = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        REG_CBR_TARGET = 3'd0,
        REG_ALPHA      = 3'd1,
        REG_BETA       = 3'd2,
        REG_STEP_MAX   = 3'd3,
        REG_STEP_MIN   = 3'd4,
        REG_FLOOR      = 3'd5,
        REG_CEIL       = 3'd6,
        REG_ON_TIME    = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SMUL_GO,
        S_SMUL_WAIT,
        S_DMUL_GO,
        S_DMUL_WAIT,
        S_CHECK,
        S_QDIV_GO,
        S_QDIV_WAIT,
        S_TXSET,
        S_RMUL_GO,
        S_RMUL_WAIT,
        S_RDIV_GO,
        S_RDIV_WAIT,
        S_FIN
    } state_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    typedef struct packed {
        logic [15:0] cbr_target;
        logic [15:0] alpha;
        logic [15:0] beta;
        logic [20:0] step_max;
        logic [20:0] step_min;
        logic [24:0] delta_floor;
        logic [24:0] delta_ceiling;
        logic [25:0] on_time;
    } cfg_t;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [63:0] a;
        logic [31:0] b;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } unit_rsp_t;

endpackage

// ===== design/acrc_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface acrc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] busy_ratio;
    logic        ratio_valid;
    logic [31:0] now_ms;

    modport source (output valid, req_type, busy_ratio, ratio_valid, now_ms, input ready);
    modport sink (input valid, req_type, busy_ratio, ratio_valid, now_ms, output ready);
endinterface

interface acrc_out_if;
    logic        valid;
    logic        ready;
    logic        gate_open;
    logic [25:0] off_time;
    logic [24:0] duty_fraction;
    logic [15:0] smoothed_ratio;

    modport source (output valid, gate_open, off_time, duty_fraction, smoothed_ratio,
                    input ready);
    modport sink (input valid, gate_open, off_time, duty_fraction, smoothed_ratio,
                  output ready);
endinterface

// ===== design/adaptive_congestion_rate_control.sv =====
// Adaptive congestion rate control: sequencer, state and output register.
// One item at a time; transmission and control update items use the 32-step multiplies
// and 64-step divides of the shared muldiv unit. Next item is taken once the result is
// registered.
// Reset (async, active low) restores register defaults, clears state, duty = floor.
module adaptive_congestion_rate_control
    import acrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    acrc_in_if.sink     in_ch,
    acrc_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "adaptive_congestion_rate_control_macros.svh"

    cfg_t      cfg;
    unit_req_t ureq;
    unit_rsp_t ursp;

    state_t      state_reg, state_next;
    req_kind_t   kind_reg;
    logic [31:0] now_reg, last_send_reg;
    logic [15:0] earlier_reg, smooth_reg;
    logic        smooth_valid_reg;
    logic [24:0] duty_reg;
    logic [25:0] current_off_reg;
    logic signed [27:0] stp_reg;
    logic [35:0] q_reg;
    logic [63:0] prod_reg;
    logic        out_valid_reg, out_gate_reg;
    logic [25:0] out_off_reg;
    logic [24:0] out_duty_reg;
    logic [15:0] out_smooth_reg;

    logic        accept;
    logic [16:0] avg;
    logic [15:0] smooth_new;
    logic signed [16:0] err;
    logic [16:0] err_neg;
    logic [15:0] err_mag;
    logic signed [27:0] f_val, smax, smin, stp_new, nd;
    logic [24:0] duty_new;
    logic [31:0] elapsed;
    logic        gate_closed;
    logic [25:0] e_q16, rem_off;
    logic [35:0] q_new;
    logic [35:0] tx_off;
    logic [63:0] off_sum, off_clamped;
    logic        out_free;

    acrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acrc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .rsp   (ursp)
    );

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // Smooth the busy ratio
    always_comb
    begin
        avg = ({1'b0, in_ch.busy_ratio} + {1'b0, earlier_reg}) >> 1;
        if (smooth_valid_reg)
        begin
            smooth_new = 16'(({1'b0, smooth_reg, 1'b0} + {2'b0, avg[15:0]}) >> 2);
        end
        else
        begin
            smooth_new = avg[15:0];
        end
    end

    // Form the ratio error and the clamped step
    always_comb
    begin
        err     = $signed({1'b0, cfg.cbr_target}) - $signed({1'b0, smooth_reg});
        err_neg = 17'(-err);
        err_mag = err[16] ? err_neg[15:0] : err[15:0];
        f_val   = err[16] ? -$signed({4'b0, ursp.result[31:8]})
                          : $signed({4'b0, ursp.result[31:8]});
        smax    = $signed({7'b0, cfg.step_max});
        smin    = $signed({{7{cfg.step_min[20]}}, cfg.step_min});
        if (!err[16] && (err != 17'sd0))
        begin
            stp_new = (f_val < smax) ? f_val : smax;
        end
        else
        begin
            stp_new = (f_val > smin) ? f_val : smin;
        end
    end

    // Decay delta, add the step and clamp
    always_comb
    begin
        nd = $signed({3'b0, ursp.result[40:16]}) + stp_reg;
        if (nd > $signed({3'b0, cfg.delta_ceiling}))
        begin
            duty_new = cfg.delta_ceiling;
        end
        else if (nd < $signed({3'b0, cfg.delta_floor}))
        begin
            duty_new = cfg.delta_floor;
        end
        else
        begin
            duty_new = nd[24:0];
        end
    end

    // Gate timing terms
    always_comb
    begin
        elapsed     = now_reg - last_send_reg;
        gate_closed = elapsed < {22'b0, current_off_reg[25:16]};
        e_q16       = {elapsed[9:0], 16'b0};
        rem_off     = current_off_reg - e_q16;
        q_new       = (ursp.result > {28'b0, Q_SAT}) ? Q_SAT : ursp.result[35:0];
        tx_off      = ((duty_reg != 25'd0) && (q_reg > {10'b0, OFF_LOW})) ? q_reg
                                                                        : {10'b0, OFF_LOW};
        off_sum     = ursp.result + {38'b0, e_q16};
        if (off_sum < {38'b0, OFF_LOW})
        begin
            off_clamped = {38'b0, OFF_LOW};
        end
        else if (off_sum > {38'b0, OFF_HIGH})
        begin
            off_clamped = {38'b0, OFF_HIGH};
        end
        else
        begin
            off_clamped = off_sum;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_kind_t'(in_ch.req_type))
                        REQ_UPDATE: state_next = in_ch.ratio_valid ? S_SMUL_GO : S_FIN;
                        REQ_TX:     state_next = (duty_reg == 25'd0) ? S_TXSET : S_QDIV_GO;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_SMUL_GO:   state_next = S_SMUL_WAIT;
            S_SMUL_WAIT: state_next = ursp.done ? S_DMUL_GO : S_SMUL_WAIT;
            S_DMUL_GO:   state_next = S_DMUL_WAIT;
            S_DMUL_WAIT: state_next = ursp.done ? S_CHECK : S_DMUL_WAIT;
            S_CHECK:
            begin
                if (!gate_closed)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = (duty_reg == 25'd0) ? S_RMUL_GO : S_QDIV_GO;
                end
            end
            S_QDIV_GO:   state_next = S_QDIV_WAIT;
            S_QDIV_WAIT:
            begin
                if (ursp.done)
                begin
                    state_next = (kind_reg == REQ_TX) ? S_TXSET : S_RMUL_GO;
                end
            end
            S_TXSET:     state_next = S_FIN;
            S_RMUL_GO:   state_next = S_RMUL_WAIT;
            S_RMUL_WAIT: state_next = ursp.done ? S_RDIV_GO : S_RMUL_WAIT;
            S_RDIV_GO:   state_next = S_RDIV_WAIT;
            S_RDIV_WAIT: state_next = ursp.done ? S_FIN : S_RDIV_WAIT;
            S_FIN:       state_next = out_free ? S_IDLE : S_FIN;
            default:     state_next = S_IDLE;
        endcase
    end

    // Unit requests and input ready
    always_comb
    begin
        ureq.start = 1'b0;
        ureq.op    = OP_MUL;
        ureq.a     = 64'b0;
        ureq.b     = 32'b0;
        case (state_reg)
            S_SMUL_GO:
            begin
                ureq.start = 1'b1;
                ureq.a     = {48'b0, err_mag};
                ureq.b     = {16'b0, cfg.beta};
            end
            S_DMUL_GO:
            begin
                ureq.start = 1'b1;
                ureq.a     = {39'b0, duty_reg};
                ureq.b     = {15'b0, 17'h10000 - {1'b0, cfg.alpha}};
            end
            S_QDIV_GO:
            begin
                ureq.start = 1'b1;
                ureq.op    = OP_DIV;
                ureq.a     = {14'b0, cfg.on_time, 24'b0};
                ureq.b     = {7'b0, duty_reg};
            end
            S_RMUL_GO:
            begin
                ureq.start = 1'b1;
                ureq.a     = {28'b0, q_reg};
                ureq.b     = {6'b0, rem_off};
            end
            S_RDIV_GO:
            begin
                ureq.start = 1'b1;
                ureq.op    = OP_DIV;
                ureq.a     = prod_reg;
                ureq.b     = {6'b0, current_off_reg};
            end
            default:
            begin
                ureq.start = 1'b0;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg         <= REQ_QUERY;
            earlier_reg      <= 16'b0;
            smooth_reg       <= 16'b0;
            smooth_valid_reg <= 1'b0;
            duty_reg         <= FLOOR_RST;
            last_send_reg    <= 32'b0;
            current_off_reg  <= 26'b0;
        end
        else
        begin
            if (accept)
            begin
                kind_reg <= req_kind_t'(in_ch.req_type);
                if (req_kind_t'(in_ch.req_type) == REQ_SAMPLE)
                begin
                    earlier_reg <= in_ch.ratio_valid ? in_ch.busy_ratio : 16'b0;
                end
                if ((req_kind_t'(in_ch.req_type) == REQ_UPDATE) && in_ch.ratio_valid)
                begin
                    smooth_reg       <= smooth_new;
                    smooth_valid_reg <= 1'b1;
                end
            end
            if ((state_reg == S_DMUL_WAIT) && ursp.done)
            begin
                duty_reg <= duty_new;
            end
            if (state_reg == S_TXSET)
            begin
                last_send_reg   <= now_reg;
                current_off_reg <= (tx_off > {10'b0, OFF_HIGH}) ? OFF_HIGH : tx_off[25:0];
            end
            if ((state_reg == S_RDIV_WAIT) && ursp.done)
            begin
                current_off_reg <= off_clamped[25:0];
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= in_ch.now_ms;
        end
        if ((state_reg == S_SMUL_WAIT) && ursp.done)
        begin
            stp_reg <= stp_new;
        end
        if (state_reg == S_CHECK)
        begin
            q_reg <= Q_SAT;
        end
        if ((state_reg == S_QDIV_WAIT) && ursp.done)
        begin
            q_reg <= q_new;
        end
        if ((state_reg == S_RMUL_WAIT) && ursp.done)
        begin
            prod_reg <= ursp.result;
        end
    end

    // Output register: load on finish, drop on take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            out_gate_reg   <= !gate_closed;
            out_off_reg    <= current_off_reg;
            out_duty_reg   <= duty_reg;
            out_smooth_reg <= smooth_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.gate_open      = out_gate_reg;
    assign out_ch.off_time       = out_off_reg;
    assign out_ch.duty_fraction  = out_duty_reg;
    assign out_ch.smoothed_ratio = out_smooth_reg;

    // Checks
    `ACRC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, !in_ch.ready)
    `ACRC_ASSERT_IMP(a_done_when_waited, clk, rst_n, ursp.done,
        (state_reg == S_SMUL_WAIT) || (state_reg == S_DMUL_WAIT) ||
        (state_reg == S_QDIV_WAIT) || (state_reg == S_RMUL_WAIT) ||
        (state_reg == S_RDIV_WAIT))
    `ACRC_ASSERT_IMP(a_off_in_range, clk, rst_n, 1'b1,
        (current_off_reg == 26'd0) ||
        ((current_off_reg >= OFF_LOW) && (current_off_reg <= OFF_HIGH)))

endmodule

// ===== design/acrc_regs.sv =====
// APB-style configuration register file.
module acrc_regs
    import acrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cbr_target    <= CBR_TARGET_RST;
            cfg_reg.alpha         <= ALPHA_RST;
            cfg_reg.beta          <= BETA_RST;
            cfg_reg.step_max      <= STEP_MAX_RST;
            cfg_reg.step_min      <= STEP_MIN_RST;
            cfg_reg.delta_floor   <= FLOOR_RST;
            cfg_reg.delta_ceiling <= CEIL_RST;
            cfg_reg.on_time       <= ON_TIME_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CBR_TARGET: cfg_reg.cbr_target    <= pwdata[15:0];
                REG_ALPHA:      cfg_reg.alpha         <= pwdata[15:0];
                REG_BETA:       cfg_reg.beta          <= pwdata[15:0];
                REG_STEP_MAX:   cfg_reg.step_max      <= pwdata[20:0];
                REG_STEP_MIN:   cfg_reg.step_min      <= pwdata[20:0];
                REG_FLOOR:      cfg_reg.delta_floor   <= pwdata[24:0];
                REG_CEIL:       cfg_reg.delta_ceiling <= pwdata[24:0];
                REG_ON_TIME:    cfg_reg.on_time       <= pwdata[25:0];
                default:        cfg_reg.on_time       <= cfg_reg.on_time;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (idx)
            REG_CBR_TARGET: prdata = {16'b0, cfg_reg.cbr_target};
            REG_ALPHA:      prdata = {16'b0, cfg_reg.alpha};
            REG_BETA:       prdata = {16'b0, cfg_reg.beta};
            REG_STEP_MAX:   prdata = {11'b0, cfg_reg.step_max};
            REG_STEP_MIN:   prdata = {11'b0, cfg_reg.step_min};
            REG_FLOOR:      prdata = {7'b0, cfg_reg.delta_floor};
            REG_CEIL:       prdata = {7'b0, cfg_reg.delta_ceiling};
            REG_ON_TIME:    prdata = {6'b0, cfg_reg.on_time};
            default:        prdata = 32'b0;
        endcase
    end

endmodule

// ===== design/acrc_muldiv.sv =====
// Shared bit-serial multiply / restoring divide unit around one 64-bit adder.
module acrc_muldiv
    import acrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    localparam logic [5:0] MUL_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST = 6'd63;

    logic        busy_reg, done_reg;
    op_t         op_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] acc_reg, opa_reg;
    logic [31:0] opb_reg, rem_reg;

    logic [32:0] trial;
    logic [63:0] add_x, add_y;
    logic        add_sub;
    logic [64:0] sum;

    assign trial = {rem_reg, opa_reg[63]};

    // Select adder operands: shifted accumulate, or trial subtract
    always_comb
    begin
        if (op_reg == OP_DIV)
        begin
            add_x   = {31'b0, trial};
            add_y   = {32'b0, opb_reg};
            add_sub = 1'b1;
        end
        else
        begin
            add_x   = {acc_reg[62:0], 1'b0};
            add_y   = opb_reg[cnt_reg[4:0]] ? opa_reg : 64'b0;
            add_sub = 1'b0;
        end
        sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {64'b0, add_sub};
    end

    // Advance one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= 6'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == OP_DIV) ? DIV_LAST : MUL_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= 64'b0;
            opa_reg <= req.a;
            opb_reg <= req.b;
            rem_reg <= 32'b0;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                acc_reg <= {acc_reg[62:0], sum[64]};
                rem_reg <= sum[64] ? sum[31:0] : trial[31:0];
                opa_reg <= {opa_reg[62:0], 1'b0};
            end
            else
            begin
                acc_reg <= sum[63:0];
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// ===== verif/acrc_checker.sv =====
// Checker for the adaptive congestion rate control block: tracks registers, predicts, compares.
module acrc_checker
    import acrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    acrc_in_if          in_ch,
    acrc_out_if         out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        gate_open;
        logic [25:0] off_time;
        logic [24:0] duty_fraction;
        logic [15:0] smoothed_ratio;
    } gate_status_t;

    localparam logic [63:0] OFF_LO = 64'd1638400;
    localparam logic [63:0] OFF_HI = 64'd65536000;
    localparam logic [63:0] Q_TOP  = 64'd67108864000;

    // Register copy
    logic [63:0] r_target, r_alpha, r_beta, r_step_max, r_floor, r_ceil, r_on;
    longint      r_step_min;

    // Predicted block state
    logic [63:0] p_earlier, p_smooth, p_duty, p_off;
    logic [31:0] p_last_send, p_gate_start;
    logic [41:0] p_opens_at;
    logic        p_smooth_ok;

    gate_status_t status_q[$];

    function automatic logic gate_is_open(logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - p_last_send;
        return {32'd0, elapsed} >= (p_off >> 16);
    endfunction

    function automatic logic [63:0] on_over_duty();
        logic [63:0] q;
        if (p_duty == 0)
            return Q_TOP;
        q = (r_on << 24) / p_duty;
        return (q > Q_TOP) ? Q_TOP : q;
    endfunction

    function automatic void load_off(logic [63:0] off);
        p_off      = off & 64'h3FFFFFF;
        p_opens_at = 42'({p_gate_start, 10'd0} + (p_off >> 6));
    endfunction

    function automatic void run_update(logic [63:0] busy, logic [31:0] now);
        logic [63:0] avg, mag, rem, off;
        logic [31:0] e;
        longint      err, f, stp, nd;
        avg = (busy + p_earlier) >> 1;
        if (p_smooth_ok)
            p_smooth = ((p_smooth << 1) + avg) >> 2;
        else
        begin
            p_smooth    = avg;
            p_smooth_ok = 1'b1;
        end
        err = longint'(r_target) - longint'(p_smooth);
        mag = (64'(err < 0 ? -err : err) * r_beta) >> 8;
        f = (err < 0) ? -longint'(mag) : longint'(mag);
        if (err > 0)
            stp = (f < longint'(r_step_max)) ? f : longint'(r_step_max);
        else
            stp = (f > r_step_min) ? f : r_step_min;
        nd = longint'(((64'd65536 - r_alpha) * p_duty) >> 16) + stp;
        if (nd > longint'(r_ceil))
            p_duty = r_ceil;
        else if (nd < longint'(r_floor))
            p_duty = r_floor;
        else
            p_duty = 64'(nd);
        // rescale the remaining closed time with the new delta
        if (!gate_is_open(now))
        begin
            e   = now - p_gate_start;
            rem = p_off - ({32'd0, e} << 16);
            off = {32'd0, e} << 16;
            if (p_off != 0)
                off += on_over_duty() * rem / p_off;
            if (off < OFF_LO)
                off = OFF_LO;
            if (off > OFF_HI)
                off = OFF_HI;
            load_off(off);
        end
    endfunction

    function automatic gate_status_t predict_status(logic [1:0] kind, logic [15:0] busy,
                                                    logic valid, logic [31:0] now);
        gate_status_t s;
        logic [63:0]  q, off;
        case (req_kind_t'(kind))
            REQ_SAMPLE: p_earlier = valid ? {48'd0, busy} : 64'd0;
            REQ_UPDATE:
            begin
                if (valid)
                    run_update({48'd0, busy}, now);
            end
            REQ_TX:
            begin
                q   = on_over_duty();
                off = (p_duty > 0 && q > OFF_LO) ? q : OFF_LO;
                if (off > OFF_HI)
                    off = OFF_HI;
                p_last_send  = now;
                p_gate_start = now;
                load_off(off);
            end
            default: ;
        endcase
        s.gate_open      = gate_is_open(now);
        s.off_time       = p_off[25:0];
        s.duty_fraction  = p_duty[24:0];
        s.smoothed_ratio = p_smooth[15:0];
        return s;
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [31:0] v);
        case (reg_idx_t'(idx))
            REG_CBR_TARGET: r_target   = {48'd0, v[15:0]};
            REG_ALPHA:      r_alpha    = {48'd0, v[15:0]};
            REG_BETA:       r_beta     = {48'd0, v[15:0]};
            REG_STEP_MAX:   r_step_max = {43'd0, v[20:0]};
            REG_STEP_MIN:   r_step_min = longint'(signed'(v[20:0]));
            REG_FLOOR:      r_floor    = {39'd0, v[24:0]};
            REG_CEIL:       r_ceil     = {39'd0, v[24:0]};
            REG_ON_TIME:    r_on       = {38'd0, v[25:0]};
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gate_status_t want, got;
        if (!rst_n)
        begin
            r_target    <= 64'd44564;
            r_alpha     <= 64'd1049;
            r_beta      <= 64'd79;
            r_step_max  <= 64'd8389;
            r_step_min  <= -64'sd4194;
            r_floor     <= 64'd10066;
            r_ceil      <= 64'd503316;
            r_on        <= 64'd32768;
            p_earlier   <= '0;
            p_smooth    <= '0;
            p_smooth_ok <= 1'b0;
            p_duty      <= 64'd10066;
            p_last_send <= '0;
            p_gate_start <= '0;
            p_opens_at  <= '0;
            p_off       <= '0;
            fail_count  <= 0;
            pending     <= 0;
            status_q.delete();
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready)
                write_reg(paddr[4:2], pwdata);
            // predict each accepted item
            if (in_ch.valid && in_ch.ready)
                status_q.push_back(predict_status(in_ch.req_type, in_ch.busy_ratio,
                                                  in_ch.ratio_valid, in_ch.now_ms));
            // compare each accepted result
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.gate_open, out_ch.off_time, out_ch.duty_fraction,
                        out_ch.smoothed_ratio};
                if (status_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $realtime, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (want != got)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // publish the number of results still owed
            pending <= status_q.size();
        end
    end

endmodule

// ===== verif/adaptive_congestion_rate_control_tb.sv =====
// Testbench top for the adaptive congestion rate control block: stimulus and verdict.
module adaptive_congestion_rate_control_tb;
    import acrc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          hold_cycles;
    bit          hold_done;
    logic [31:0] clock_ms;

    acrc_in_if  in_ch ();
    acrc_out_if out_ch ();

    adaptive_congestion_rate_control dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    acrc_checker chk (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Time limit
    initial
    begin
        #60000000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: stall pattern changes every 16 results, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        int mode;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            results_seen <= 0;
            hold_cycles  <= 0;
            hold_done    <= 1'b0;
        end
        else
        begin
            mode = ($urandom_range(0, 63) < 2) ? 3 : ($urandom & 32'h3);
            if (out_ch.valid && out_ch.ready)
                results_seen <= results_seen + 1;
            if (!hold_done && results_seen == 400)
            begin
                hold_done    <= 1'b1;
                hold_cycles  <= 800;
                out_ch.ready <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles  <= hold_cycles - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case ((results_seen / 16) % 4)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: out_ch.ready <= ($urandom_range(0, 9) == 0);
                    default: out_ch.ready <= (mode != 3);
                endcase
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic offer_item(req_kind_t kind, logic [15:0] busy, logic valid,
                              logic [31:0] now);
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= kind;
        in_ch.busy_ratio  <= busy;
        in_ch.ratio_valid <= valid;
        in_ch.now_ms      <= now;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_gap(int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(logic [31:0] target, logic [31:0] alpha, logic [31:0] beta,
                                 logic [31:0] smax, logic [31:0] smin, logic [31:0] floor_v,
                                 logic [31:0] ceil_v, logic [31:0] on_v);
        write_reg(REG_CBR_TARGET, target);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_BETA, beta);
        write_reg(REG_STEP_MAX, smax);
        write_reg(REG_STEP_MIN, smin);
        write_reg(REG_FLOOR, floor_v);
        write_reg(REG_CEIL, ceil_v);
        write_reg(REG_ON_TIME, on_v);
    endtask

    // Random traffic: mostly a steadily advancing clock, some jumps and wraps
    task automatic random_burst(int count);
        int          pick;
        req_kind_t   kind;
        logic [15:0] busy;
        logic        valid;
        logic [31:0] now;
        int          sent;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                kind = REQ_SAMPLE;
            else if (pick < 65)
                kind = REQ_UPDATE;
            else if (pick < 85)
                kind = REQ_TX;
            else
                kind = REQ_QUERY;
            busy  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(30000, 60000));
            valid = ($urandom_range(0, 9) != 0);
            pick  = $urandom_range(0, 99);
            if (pick < 3)
                clock_ms = $urandom;
            else if (pick < 5)
                clock_ms = 32'hFFFFFFFF - $urandom_range(0, 600);
            else if (pick < 60)
                clock_ms = clock_ms + $urandom_range(0, 40);
            else
                clock_ms = clock_ms + $urandom_range(0, 400);
            now = ($urandom_range(0, 49) == 0) ? $urandom : clock_ms;
            offer_item(kind, busy, valid, now);
            sent++;
            if ($urandom_range(0, 7) == 0)
                idle_gap($urandom_range(1, 300));
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.req_type    = REQ_QUERY;
        in_ch.busy_ratio  = '0;
        in_ch.ratio_valid = 1'b0;
        in_ch.now_ms      = '0;
        clock_ms          = 32'd1000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset settings
        offer_item(REQ_QUERY, 16'd0, 1'b0, 32'd0);
        offer_item(REQ_UPDATE, 16'hFFFF, 1'b0, 32'd5);
        offer_item(REQ_SAMPLE, 16'hFFFF, 1'b1, 32'd6);
        offer_item(REQ_UPDATE, 16'hFFFF, 1'b1, 32'd7);
        offer_item(REQ_UPDATE, 16'd0, 1'b1, 32'd8);
        offer_item(REQ_SAMPLE, 16'h1234, 1'b0, 32'd9);
        offer_item(REQ_UPDATE, 16'd0, 1'b1, 32'd10);
        offer_item(REQ_TX, 16'd0, 1'b0, 32'd100);
        offer_item(REQ_QUERY, 16'd0, 1'b0, 32'd101);
        offer_item(REQ_UPDATE, 16'd44564, 1'b1, 32'd150);
        offer_item(REQ_QUERY, 16'd0, 1'b0, 32'd1100);
        offer_item(REQ_TX, 16'd0, 1'b0, 32'hFFFFFF00);
        offer_item(REQ_UPDATE, 16'h8000, 1'b1, 32'h00000010);
        offer_item(REQ_QUERY, 16'hFFFF, 1'b1, 32'h00000400);
        offer_item(REQ_QUERY, 16'hFFFF, 1'b1, 32'hFFFFFFFF);
        offer_item(REQ_SAMPLE, 16'd0, 1'b1, 32'hAAAAAAAA);
        offer_item(REQ_UPDATE, 16'd0, 1'b1, 32'h55555555);
        drain();

        // Zero delta: floor and ceiling both zero
        load_settings(32'd65535, 32'd0, 32'd65535, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536000);
        offer_item(REQ_UPDATE, 16'd0, 1'b1, 32'd2000);
        offer_item(REQ_TX, 16'd0, 1'b0, 32'd2001);
        offer_item(REQ_UPDATE, 16'd0, 1'b1, 32'd2002);
        offer_item(REQ_QUERY, 16'd0, 1'b0, 32'd2500);
        random_burst(60);
        drain();

        // Upper extremes
        load_settings(32'd65535, 32'd0, 32'd65535, 32'd1048576, 32'h100000, 32'd0,
                      32'd16777216, 32'd67108863);
        random_burst(150);
        drain();

        // Lower extremes, inverted clamp bounds
        load_settings(32'd0, 32'd65535, 32'd1, 32'd0, 32'd0, 32'd16777216, 32'd0, 32'd1);
        random_burst(120);
        drain();

        // Moderate settings with short off-times
        load_settings(32'd30000, 32'd4000, 32'd2000, 32'd50000, 32'h1F3CB0, 32'd100000,
                      32'd8000000, 32'd327680);
        random_burst(250);
        drain();

        // Back to defaults
        load_settings(32'd44564, 32'd1049, 32'd79, 32'd8389, 32'h1FEF9E, 32'd10066,
                      32'd503316, 32'd32768);
        random_burst(250);
        drain();

        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== adaptive_congestion_rate_control.f =====
+incdir+design
design/acrc_pkg.sv
design/acrc_if.sv
design/acrc_regs.sv
design/acrc_muldiv.sv
design/adaptive_congestion_rate_control.sv
verif/acrc_checker.sv
verif/adaptive_congestion_rate_control_tb.sv
